>>> rtl/ssns_pkg.sv
// Shared types and constants for the seven-segment number sequencer.
package ssns_pkg;

  localparam logic [3:0]  DECODE_REG  = 4'h9;
  localparam logic [7:0]  MINUS_CODE  = 8'h0A;
  localparam logic [7:0]  CODEB_MAX   = 8'h0F;
  localparam logic [7:0]  DOT_BIT     = 8'h80;
  localparam logic [7:0]  MASK_ALL    = 8'hFF;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUOT_W      = 29;

  // One classified command waiting for the back end.
  typedef struct packed {
    logic        is_digit;
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  sel;
    logic [7:0]  value;
    logic        dot;
  } cmd_t;

  // One display register word.
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } word_t;

endpackage

>>> rtl/ssns_fifo.sv
// Small register-based first-in first-out queue.
module ssns_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/ssns_front.sv
// Front end: takes input items, drops invalid digit writes, forms magnitudes.
module ssns_front #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic               in_push,
  input  logic               in_command,
  input  logic signed [31:0] in_number,
  input  logic [3:0]         in_digit_select,
  input  logic [7:0]         in_digit_value,
  input  logic               in_dot,
  input  logic               cmd_full,
  output logic               cmd_push,
  output ssns_pkg::cmd_t     cmd
);

  localparam logic [3:0] DC = 4'(DIGIT_COUNT);

  logic sel_ok;
  logic neg;

  assign neg    = in_number[31];
  assign sel_ok = (in_digit_select != 4'd0) && (in_digit_select <= DC);

  always_comb begin
    cmd.is_digit = in_command;
    cmd.neg      = neg && !in_command;
    // The most negative value wraps to its own unsigned magnitude.
    cmd.mag      = neg ? (32'd0 - 32'(in_number)) : 32'(in_number);
    cmd.sel      = in_digit_select;
    cmd.value    = in_digit_value;
    cmd.dot      = in_dot;
  end

  // An out-of-range digit write is taken but causes no transfer.
  assign cmd_push = in_push && !cmd_full && (!in_command || sel_ok);

endmodule

>>> rtl/ssns_back.sv
// Back end: converts numbers to digits and emits display register words.
module ssns_back #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  ssns_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               out_full,
  output logic               out_push,
  output ssns_pkg::word_t    out_word
);

  localparam logic [3:0] DC = 4'(DIGIT_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_REM, S_CHECK, S_DIGIT} state_t;
  typedef enum logic [1:0] {NX_DIV, NX_MINUS, NX_DONE} next_t;

  state_t                        state_r, state_nxt;
  next_t                         nx_r, nx_nxt;
  logic [7:0]                    mask_r, mask_nxt;
  logic [31:0]                   mag_r, mag_nxt;
  logic [ssns_pkg::QUOT_W-1:0]   q_r, q_nxt;
  logic                          neg_r, neg_nxt;
  logic [3:0]                    count_r, count_nxt;
  logic [3:0]                    digit_r, digit_nxt;
  logic [7:0]                    val_r, val_nxt;
  logic                          dot_r, dot_nxt;

  logic [63:0] prod;
  logic [3:0]  q_ten_lo;
  logic [3:0]  rem;
  logic [3:0]  count_inc;
  logic [2:0]  bit_idx;
  logic [7:0]  bit_sel;
  logic        codeb;
  logic        change;
  logic [7:0]  mask_new;
  logic [7:0]  digit_data;

  assign prod      = 64'(mag_r) * 64'(ssns_pkg::RECIP_TEN);
  // Only the low nibble of mag - 10*q matters, since the remainder is below ten.
  assign q_ten_lo  = {q_r[2:0], 1'b0} + {q_r[0], 3'b000};
  assign rem       = mag_r[3:0] - q_ten_lo;
  assign count_inc = count_r + 4'd1;
  assign bit_idx   = 3'(digit_r - 4'd1);
  assign bit_sel   = 8'd1 << bit_idx;
  assign codeb     = (val_r <= ssns_pkg::CODEB_MAX);
  assign change    = codeb != mask_r[bit_idx];
  assign mask_new  = codeb ? (mask_r | bit_sel) : (mask_r & ~bit_sel);
  assign digit_data = (codeb && dot_r) ? (val_r | ssns_pkg::DOT_BIT) : val_r;

  always_comb begin
    state_nxt = state_r;
    nx_nxt    = nx_r;
    mask_nxt  = mask_r;
    mag_nxt   = mag_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    count_nxt = count_r;
    digit_nxt = digit_r;
    val_nxt   = val_r;
    dot_nxt   = dot_r;
    cmd_pop   = 1'b0;
    out_push  = 1'b0;
    out_word  = '0;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.is_digit) begin
            digit_nxt = cmd.sel;
            val_nxt   = cmd.value;
            dot_nxt   = cmd.dot;
            nx_nxt    = NX_DONE;
            state_nxt = S_CHECK;
          end else begin
            mag_nxt   = cmd.mag;
            neg_nxt   = cmd.neg;
            count_nxt = 4'd0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        q_nxt     = prod[ssns_pkg::RECIP_SHIFT +: ssns_pkg::QUOT_W];
        state_nxt = S_REM;
      end
      S_REM: begin
        count_nxt = count_inc;
        digit_nxt = count_inc;
        val_nxt   = {4'd0, rem};
        dot_nxt   = 1'b0;
        mag_nxt   = 32'(q_r);
        if ((q_r != '0) && (count_inc < DC)) begin
          nx_nxt = NX_DIV;
        end else if (neg_r && (count_inc < DC)) begin
          nx_nxt = NX_MINUS;
        end else begin
          nx_nxt = NX_DONE;
        end
        state_nxt = S_CHECK;
      end
      S_CHECK, S_DIGIT: begin
        if (!out_full) begin
          out_push = 1'b1;
          if ((state_r == S_CHECK) && change) begin
            // The decode mode word for this digit goes out ahead of it.
            out_word.addr = ssns_pkg::DECODE_REG;
            out_word.data = mask_new;
            out_word.last = 1'b0;
            mask_nxt      = mask_new;
            state_nxt     = S_DIGIT;
          end else begin
            out_word.addr = digit_r;
            out_word.data = digit_data;
            out_word.last = (nx_r == NX_DONE);
            case (nx_r)
              NX_DIV: begin
                state_nxt = S_DIV;
              end
              NX_MINUS: begin
                digit_nxt = count_inc;
                val_nxt   = ssns_pkg::MINUS_CODE;
                dot_nxt   = 1'b0;
                nx_nxt    = NX_DONE;
                state_nxt = S_CHECK;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nx_r    <= NX_DONE;
      mask_r  <= ssns_pkg::MASK_ALL;
      count_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      nx_r    <= nx_nxt;
      mask_r  <= mask_nxt;
      count_r <= count_nxt;
    end
    mag_r   <= mag_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    digit_r <= digit_nxt;
    val_r   <= val_nxt;
    dot_r   <= dot_nxt;
  end

endmodule

>>> rtl/seven_segment_number_sequencer.sv
// The back end takes a command from the input queue only when it has finished the last one.
// For each number digit it divides by ten, forms the remainder and sends the digit word; a
// digit write or minus word is just sent, and a decode mask word goes out first whenever a
// digit changes mode. Sending stalls while the output queue is full; a two-entry queue
// holds pending inputs. Reset is synchronous and active low; it empties both queues and
// sets the decode mask to all digits code-B.
module seven_segment_number_sequencer #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_command,
  input  logic signed [31:0] in_number,
  input  logic [3:0]         in_digit_select,
  input  logic [7:0]         in_digit_value,
  input  logic               in_dot,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_reg_address,
  output logic [7:0]         out_reg_data,
  output logic               out_last
);

  localparam int CMD_W  = $bits(ssns_pkg::cmd_t);
  localparam int WORD_W = $bits(ssns_pkg::word_t);

  ssns_pkg::cmd_t  cmd_in, cmd_out;
  ssns_pkg::word_t word_in, word_out;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic            word_push, word_full;

  ssns_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .in_push         (in_push),
    .in_command      (in_command),
    .in_number       (in_number),
    .in_digit_select (in_digit_select),
    .in_digit_value  (in_digit_value),
    .in_dot          (in_dot),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  assign in_full = cmd_full;

  ssns_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  ssns_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (word_full),
    .out_push  (word_push),
    .out_word  (word_in)
  );

  ssns_fifo #(.WIDTH(WORD_W), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (word_push),
    .din   (word_in),
    .full  (word_full),
    .pop   (out_pop),
    .dout  (word_out),
    .empty (out_empty)
  );

  assign out_reg_address = word_out.addr;
  assign out_reg_data    = word_out.data;
  assign out_last        = word_out.last;

`ifndef ASSERT_OFF
  // A decode mode word always precedes its digit word, so it never ends an item.
  a_mask_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_reg_address == ssns_pkg::DECODE_REG) |-> !out_last)
    else $error("decode mode word marked as last");

  // Every word addresses either a shown digit or the decode mode register.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_reg_address == ssns_pkg::DECODE_REG) ||
                   ((out_reg_address != 4'd0) && (out_reg_address <= 4'(DIGIT_COUNT))))
    else $error("register address out of range");

  // The output queue comes out of reset empty and the input queue not full.
  a_leave_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the seven-segment number sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_NUMBER = 1'b0;
  localparam logic CMD_DIGIT  = 1'b1;
  localparam int   DIGITS     = 8;
  localparam int   RANDOM_REQS = 450;
  localparam int   TAIL_REQS  = 60;
  localparam int   CYCLE_LIMIT = 600000;
  localparam int   SETTLE_CYCLES = 60;

  typedef struct {
    logic        command;
    logic [31:0] number;
    logic [3:0]  sel;
    logic [7:0]  value;
    logic        dot;
    logic        hold;   // wait until every queued register word has drained
  } display_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_command = 1'b0;
  logic signed [31:0] in_number = '0;
  logic [3:0] in_digit_select = '0;
  logic [7:0] in_digit_value = '0;
  logic in_dot = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [3:0] out_reg_address;
  logic [7:0] out_reg_data;
  logic out_last;

  display_req_t    pending_reqs[$];
  ssns_pkg::word_t expected_words[$];
  ssns_pkg::word_t staged_words[$];
  logic [7:0]      mask_model;
  int              mismatches = 0;
  int              cycles = 0;
  bit              req_taken = 1'b0;
  bit              presenting = 1'b0;
  int              send_gap = 0;
  int              pop_stall = 0;

  seven_segment_number_sequencer #(.DIGIT_COUNT(DIGITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_command(in_command),
    .in_number(in_number),
    .in_digit_select(in_digit_select),
    .in_digit_value(in_digit_value),
    .in_dot(in_dot),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_reg_address(out_reg_address),
    .out_reg_data(out_reg_data),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A digit write, preceded by a decode-mode word when the digit changes mode.
  function automatic void stage_digit(input logic [3:0] digit, input logic [7:0] value,
                                      input logic dot);
    logic [7:0]      bit_sel;
    logic            codeb;
    ssns_pkg::word_t w;
    bit_sel = 8'd1 << (digit - 4'd1);
    codeb = value <= ssns_pkg::CODEB_MAX;
    w.last = 1'b0;
    if ((codeb && (mask_model & bit_sel) == 8'd0) ||
        (!codeb && (mask_model & bit_sel) != 8'd0)) begin
      mask_model = mask_model ^ bit_sel;
      w.addr = ssns_pkg::DECODE_REG;
      w.data = mask_model;
      staged_words.push_back(w);
    end
    w.addr = digit;
    w.data = (codeb && dot) ? (value | ssns_pkg::DOT_BIT) : value;
    staged_words.push_back(w);
  endfunction

  function automatic void predict_words(input display_req_t r);
    logic [31:0]     mag;
    int              count;
    ssns_pkg::word_t w;
    if (r.command == CMD_DIGIT) begin
      if (r.sel >= 4'd1 && r.sel <= 4'(DIGITS)) stage_digit(r.sel, r.value, r.dot);
    end else begin
      mag = r.number[31] ? -r.number : r.number;
      count = 0;
      if (mag == 32'd0) begin
        stage_digit(4'd1, 8'd0, 1'b0);
      end else begin
        while (count < DIGITS) begin
          count++;
          stage_digit(4'(count), 8'(mag % 32'd10), 1'b0);
          mag = mag / 32'd10;
          if (mag == 32'd0) break;
        end
        if (r.number[31] && count < DIGITS)
          stage_digit(4'(count + 1), ssns_pkg::MINUS_CODE, 1'b0);
      end
    end
    for (int i = 0; i < staged_words.size(); i++) begin
      w = staged_words[i];
      w.last = (i == staged_words.size() - 1);
      expected_words.push_back(w);
    end
    staged_words.delete();
  endfunction

  function automatic int phase_pct(input int phase);
    case (phase % 4)
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 70;
    endcase
  endfunction

  task automatic queue_number(input logic [31:0] n, input logic hold);
    display_req_t r;
    r.command = CMD_NUMBER;
    r.number = n;
    r.sel = 4'($urandom);
    r.value = 8'($urandom);
    r.dot = 1'($urandom);
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_digit(input logic [3:0] sel, input logic [7:0] value, input logic dot,
                             input logic hold);
    display_req_t r;
    r.command = CMD_DIGIT;
    r.number = $urandom;
    r.sel = sel;
    r.value = value;
    r.dot = dot;
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    display_req_t    r;
    ssns_pkg::word_t exp_w;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: addr=%0d data=0x%02h last=%0b",
                     out_reg_address, out_reg_data, out_last);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.addr !== out_reg_address || exp_w.data !== out_reg_data ||
              exp_w.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr=%0d data=0x%02h last=%0b, got %0d 0x%02h %0b",
                       exp_w.addr, exp_w.data, exp_w.last,
                       out_reg_address, out_reg_data, out_last);
          end
        end
      end
      if (in_push && !in_full) begin
        r.command = in_command;
        r.number = in_number;
        r.sel = in_digit_select;
        r.value = in_digit_value;
        r.dot = in_dot;
        r.hold = 1'b0;
        predict_words(r);
        req_taken = 1'b1;
      end
    end
  end

  // Request driver: changes inputs at the falling edge.
  always @(negedge clk) begin
    display_req_t r;
    int           pct;
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        presenting = 1'b0;
      end
      pct = (pending_reqs.size() < TAIL_REQS) ? 0 : phase_pct(pending_reqs.size() / 64);
      if (!presenting && pending_reqs.size() > 0) begin
        if (pending_reqs[0].hold && expected_words.size() != 0) begin
          send_gap = 0;
        end else begin
          if (send_gap == 0 && $urandom_range(0, 99) < pct) send_gap = $urandom_range(1, 8);
          if (send_gap > 0) begin
            send_gap--;
          end else begin
            r = pending_reqs.pop_front();
            presenting = 1'b1;
            in_command <= r.command;
            in_number <= r.number;
            in_digit_select <= r.sel;
            in_digit_value <= r.value;
            in_dot <= r.dot;
          end
        end
      end
      in_push <= presenting;
    end
  end

  // Result consumer: stalls in random bursts.
  always @(negedge clk) begin
    int pct;
    if (rst_n) begin
      pct = (pending_reqs.size() < TAIL_REQS) ? 0 : phase_pct(pending_reqs.size() / 40 + 1);
      if (pop_stall == 0 && $urandom_range(0, 99) < pct) pop_stall = $urandom_range(1, 8);
      if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          ndig;
    longint      span;
    logic [31:0] mag;
    logic [3:0]  sel;
    logic [7:0]  value;
    mask_model = ssns_pkg::MASK_ALL;

    // Directed part: extremes, truncation, the minus code and decode-mode changes.
    queue_number(32'd0, 1'b0);
    queue_number(32'd1, 1'b0);
    queue_number(-32'sd1, 1'b0);
    queue_number(-32'sd10, 1'b0);
    queue_number(32'd12345678, 1'b0);
    queue_number(-32'sd9999999, 1'b0);
    queue_number(-32'sd99999999, 1'b0);
    queue_number(32'd100000000, 1'b0);
    queue_number(32'h7FFF_FFFF, 1'b0);
    queue_number(32'h8000_0000, 1'b0);
    queue_digit(4'd1, 8'd0, 1'b1, 1'b0);
    queue_digit(4'd8, 8'd15, 1'b0, 1'b0);
    queue_digit(4'd3, 8'd16, 1'b1, 1'b0);
    queue_digit(4'd3, 8'd255, 1'b0, 1'b0);
    queue_digit(4'd3, 8'd5, 1'b1, 1'b0);
    queue_digit(4'd0, 8'd7, 1'b1, 1'b0);
    queue_digit(4'd9, 8'd200, 1'b0, 1'b0);
    queue_digit(4'd15, 8'd3, 1'b0, 1'b0);
    queue_digit(4'd1, 8'h80, 1'b1, 1'b0);
    queue_digit(4'd8, 8'h7F, 1'b0, 1'b0);
    queue_digit(4'd5, 8'hAA, 1'b0, 1'b0);
    // Showing a number must restore code-B on every digit it touches.
    queue_number(32'h8000_0000, 1'b1);
    queue_digit(4'd2, 8'h55, 1'b0, 1'b0);
    queue_number(-32'sd123, 1'b0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        ndig = $urandom_range(0, 9);
        if (ndig == 0) begin
          mag = $urandom;
        end else begin
          span = 1;
          repeat (ndig) span = span * 10;
          mag = 32'($urandom % span);
          if ($urandom_range(0, 1) == 1) mag = -mag;
        end
        queue_number(mag, (i % 110) == 55);
      end else if (kind < 90) begin
        sel = 4'($urandom_range(1, DIGITS));
        case ($urandom_range(0, 2))
          0: value = 8'($urandom_range(0, 15));
          1: value = 8'($urandom_range(16, 255));
          default: value = 8'($urandom);
        endcase
        queue_digit(sel, value, 1'($urandom), (i % 110) == 55);
      end else begin
        sel = 4'($urandom_range(0, 7));
        if (sel != 4'd0) sel = sel + 4'd8;
        queue_digit(sel, 8'($urandom), 1'($urandom), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_push) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
